[sv/assert_macros.svh]
// assertion macros shared by the controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising clock edge, quiet while reset is high
`define PDC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked at every rising clock edge, reset included
`define PDC_ASSERT_RESET(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[sv/pdc_pkg.sv]
// types, constants and arithmetic helpers of the pid controller
`timescale 1ns / 1ps

package pdc_pkg;

   localparam int DATA_WIDTH      = 16;
   localparam int FRAC_BITS       = 8;
   localparam int DW1             = DATA_WIDTH + 1;
   localparam int PROD_W          = 2 * DATA_WIDTH + 2;
   localparam int CLAMP_W         = PROD_W + 1;
   localparam int SUM_W           = DATA_WIDTH + 2;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   localparam data_type VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam data_type VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'((1 << FRAC_BITS) >> 1);

   // register reset values
   localparam logic        RST_DIRECTION       = 1'b1;
   localparam logic [31:0] RST_OUTPUT_LIMITS   = 32'h7FFF_8000;
   localparam logic [31:0] RST_INTEGRAL_LIMITS = 32'h7FFF_8000;
   localparam logic [63:0] RST_PD_LIMITS       = 64'h7FFF_8000_7FFF_8000;
   localparam logic [63:0] RST_INPUT_WINDOW    = 64'h7FFF_8000_0000_0000;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_KP              = 3'd0,
      CSR_KI_DT           = 3'd1,
      CSR_KD_DT           = 3'd2,
      CSR_DIRECTION       = 3'd3,
      CSR_OUTPUT_LIMITS   = 3'd4,
      CSR_INTEGRAL_LIMITS = 3'd5,
      CSR_PD_LIMITS       = 3'd6,
      CSR_INPUT_WINDOW    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic     mode;
      data_type sample;
   } req_payload_type;

   typedef struct packed {
      data_type control_out;
      logic     updated;
      logic     out_limited;
      logic     p_limited;
      logic     i_limited;
      logic     d_limited;
   } rsp_payload_type;

   typedef struct packed {
      data_type kp;
      data_type ki_dt;
      data_type kd_dt;
      logic     direction;
      data_type out_lo;
      data_type out_hi;
      data_type int_lo;
      data_type int_hi;
      data_type p_lo;
      data_type p_hi;
      data_type d_lo;
      data_type d_hi;
      data_type trig_lo;
      data_type trig_hi;
      data_type con_lo;
      data_type con_hi;
   } cfg_type;

   typedef struct packed {
      logic     valid;
      logic     clear;
      logic     counted;
      data_type x;
   } stage_a_type;

   typedef struct packed {
      logic valid;
      logic updated;
   } stage_b_type;

   typedef struct packed {
      data_type p;
      data_type i;
      data_type d;
   } terms_type;

   // saturate a one-bit-wider value to the data range
   function automatic data_type sat_fn(input logic signed [DW1-1:0] v);
      data_type r;
      if (v > DW1'(VAL_MAX)) r = VAL_MAX;
      else if (v < DW1'(VAL_MIN)) r = VAL_MIN;
      else r = DATA_WIDTH'(v);
      return r;
   endfunction

   // lower limit checked first; with crossed limits it wins only for values below it
   function automatic data_type clamp_fn(input logic signed [CLAMP_W-1:0] v,
                                         input data_type lo, input data_type hi);
      data_type r;
      if (v < CLAMP_W'(lo)) r = lo;
      else if (v > CLAMP_W'(hi)) r = hi;
      else r = DATA_WIDTH'(v);
      return r;
   endfunction

   // fixed-point product, rounded to nearest with ties upward
   function automatic logic signed [PROD_W-1:0] fxmul_fn(input data_type gain,
                                                         input logic signed [DW1-1:0] value);
      logic signed [PROD_W-1:0] prod;
      prod = PROD_W'(gain) * PROD_W'(value);
      return (prod + ROUND_HALF) >>> FRAC_BITS;
   endfunction

endpackage

[sv/pdc_csr.sv]
// configuration registers and their unpacking into limit fields
`timescale 1ns / 1ps

module pdc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [pdc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [pdc_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output pdc_pkg::cfg_type                     cfg
);
   import pdc_pkg::*;

   data_type    kp_ff, ki_dt_ff, kd_dt_ff;
   logic        direction_ff;
   logic [31:0] output_limits_ff, integral_limits_ff;
   logic [63:0] pd_limits_ff, input_window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff              <= '0;
         ki_dt_ff           <= '0;
         kd_dt_ff           <= '0;
         direction_ff       <= RST_DIRECTION;
         output_limits_ff   <= RST_OUTPUT_LIMITS;
         integral_limits_ff <= RST_INTEGRAL_LIMITS;
         pd_limits_ff       <= RST_PD_LIMITS;
         input_window_ff    <= RST_INPUT_WINDOW;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_KP:              kp_ff              <= csr_wdata[DATA_WIDTH-1:0];
            CSR_KI_DT:           ki_dt_ff           <= csr_wdata[DATA_WIDTH-1:0];
            CSR_KD_DT:           kd_dt_ff           <= csr_wdata[DATA_WIDTH-1:0];
            CSR_DIRECTION:       direction_ff       <= csr_wdata[0];
            CSR_OUTPUT_LIMITS:   output_limits_ff   <= csr_wdata[31:0];
            CSR_INTEGRAL_LIMITS: integral_limits_ff <= csr_wdata[31:0];
            CSR_PD_LIMITS:       pd_limits_ff       <= csr_wdata;
            CSR_INPUT_WINDOW:    input_window_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.kp        = kp_ff;
      cfg.ki_dt     = ki_dt_ff;
      cfg.kd_dt     = kd_dt_ff;
      cfg.direction = direction_ff;
      cfg.out_lo    = output_limits_ff[DATA_WIDTH-1:0];
      cfg.out_hi    = output_limits_ff[2*DATA_WIDTH-1:DATA_WIDTH];
      cfg.int_lo    = integral_limits_ff[DATA_WIDTH-1:0];
      cfg.int_hi    = integral_limits_ff[2*DATA_WIDTH-1:DATA_WIDTH];
      cfg.p_lo      = pd_limits_ff[DATA_WIDTH-1:0];
      cfg.p_hi      = pd_limits_ff[2*DATA_WIDTH-1:DATA_WIDTH];
      cfg.d_lo      = pd_limits_ff[3*DATA_WIDTH-1:2*DATA_WIDTH];
      cfg.d_hi      = pd_limits_ff[4*DATA_WIDTH-1:3*DATA_WIDTH];
      cfg.trig_lo   = input_window_ff[DATA_WIDTH-1:0];
      cfg.trig_hi   = input_window_ff[2*DATA_WIDTH-1:DATA_WIDTH];
      cfg.con_lo    = input_window_ff[3*DATA_WIDTH-1:2*DATA_WIDTH];
      cfg.con_hi    = input_window_ff[4*DATA_WIDTH-1:3*DATA_WIDTH];
   end

endmodule

[sv/pdc_front.sv]
// input register with deadband, window test and trigger offset
`timescale 1ns / 1ps

module pdc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  pdc_pkg::req_payload_type  req_data,
   input  pdc_pkg::cfg_type          cfg,
   input  logic                      b_ready,
   output pdc_pkg::stage_a_type      a_out
);
   import pdc_pkg::*;

   logic     a_valid_ff, a_clear_ff, a_counted_ff;
   data_type a_x_ff;
   logic     clear_in, counted_in, in_window;
   data_type x_in;
   logic     take;

   assign req_ready = !a_valid_ff || b_ready;
   assign take      = req_valid && req_ready;

   // clear mode tested first, then the upper trigger
   always_comb begin
      in_window  = (req_data.sample <= cfg.con_hi) && (req_data.sample >= cfg.con_lo);
      clear_in   = 1'b0;
      counted_in = 1'b0;
      x_in       = '0;
      if (req_data.mode) begin
         clear_in = 1'b1;
      end else if (req_data.sample >= cfg.trig_hi) begin
         counted_in = in_window;
         x_in       = sat_fn(DW1'(req_data.sample) - DW1'(cfg.trig_hi));
      end else if (req_data.sample <= cfg.trig_lo) begin
         counted_in = in_window;
         x_in       = sat_fn(DW1'(req_data.sample) - DW1'(cfg.trig_lo));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_ready) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         a_clear_ff   <= clear_in;
         a_counted_ff <= counted_in;
         a_x_ff       <= x_in;
      end
   end

   assign a_out = '{valid: a_valid_ff, clear: a_clear_ff, counted: a_counted_ff, x: a_x_ff};

endmodule

[sv/pdc_terms.sv]
// p, i and d term update with the integral and previous-value state
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pdc_terms (
   input  logic                  clock,
   input  logic                  reset,
   input  pdc_pkg::stage_a_type  a,
   input  pdc_pkg::cfg_type      cfg,
   output logic                  b_ready,
   input  logic                  c_ready,
   output pdc_pkg::stage_b_type  b_out,
   output pdc_pkg::terms_type    terms
);
   import pdc_pkg::*;

   data_type p_term_ff, i_term_ff, d_term_ff, prev_ff;
   data_type p_term_in, i_term_in, d_term_in, prev_in;
   logic     b_valid_ff, b_updated_ff;
   logic     adv;

   logic signed [DW1-1:0]     delta;
   logic signed [PROD_W-1:0]  p_raw, d_raw, di;
   logic signed [CLAMP_W-1:0] i_sum;
   data_type                  p_cl, d_cl, i_cl, p_neg, d_neg;

   assign b_ready = !b_valid_ff || c_ready;
   assign adv     = a.valid && b_ready;

   always_comb begin
      delta = DW1'(a.x) - DW1'(prev_ff);
      p_raw = fxmul_fn(cfg.kp, DW1'(a.x));
      d_raw = fxmul_fn(cfg.kd_dt, delta);
      di    = fxmul_fn(cfg.ki_dt, DW1'(a.x));
      p_cl  = clamp_fn(CLAMP_W'(p_raw), cfg.p_lo, cfg.p_hi);
      d_cl  = clamp_fn(CLAMP_W'(d_raw), cfg.d_lo, cfg.d_hi);
      // reverse sense subtracts in the integral
      if (cfg.direction) i_sum = CLAMP_W'(i_term_ff) + CLAMP_W'(di);
      else               i_sum = CLAMP_W'(i_term_ff) - CLAMP_W'(di);
      i_cl  = clamp_fn(i_sum, cfg.int_lo, cfg.int_hi);
      p_neg = sat_fn(-DW1'(p_cl));
      d_neg = sat_fn(-DW1'(d_cl));
   end

   always_comb begin
      p_term_in = p_term_ff;
      i_term_in = i_term_ff;
      d_term_in = d_term_ff;
      prev_in   = prev_ff;
      if (a.clear) begin
         p_term_in = '0;
         i_term_in = '0;
         d_term_in = '0;
      end else if (a.counted) begin
         p_term_in = cfg.direction ? p_cl : p_neg;
         i_term_in = i_cl;
         d_term_in = cfg.direction ? d_cl : d_neg;
         prev_in   = a.x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_term_ff  <= '0;
         i_term_ff  <= '0;
         d_term_ff  <= '0;
         prev_ff    <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            p_term_ff <= p_term_in;
            i_term_ff <= i_term_in;
            d_term_ff <= d_term_in;
            prev_ff   <= prev_in;
         end
         if (b_ready) b_valid_ff <= a.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) b_updated_ff <= a.counted && !a.clear;
   end

   assign b_out = '{valid: b_valid_ff, updated: b_updated_ff};
   assign terms = '{p: p_term_ff, i: i_term_ff, d: d_term_ff};

   `PDC_ASSERT(a_clear_zeroes_terms, adv && a.clear |=> p_term_ff == '0 && i_term_ff == '0 && d_term_ff == '0, "clear beat left a term nonzero")
   `PDC_ASSERT(a_prev_holds, !(adv && a.counted) |=> $stable(prev_ff), "previous value moved without a counted beat")
   `PDC_ASSERT(a_terms_hold, !adv |=> $stable(p_term_ff) && $stable(i_term_ff) && $stable(d_term_ff), "terms moved while the stage held")

endmodule

[sv/pdc_out.sv]
// term sum, output clamp, limit flags and result register
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pdc_out (
   input  logic                      clock,
   input  logic                      reset,
   input  pdc_pkg::stage_b_type      b,
   input  pdc_pkg::terms_type        terms,
   input  pdc_pkg::cfg_type          cfg,
   output logic                      c_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output pdc_pkg::rsp_payload_type  rsp_data
);
   import pdc_pkg::*;

   logic                    rsp_valid_ff;
   rsp_payload_type         rsp_data_ff, rsp_data_in;
   logic signed [SUM_W-1:0] sum;
   logic                    adv;

   assign c_ready = !rsp_valid_ff || rsp_ready;
   assign adv     = b.valid && c_ready;

   always_comb begin
      sum = SUM_W'(terms.p) + SUM_W'(terms.i) + SUM_W'(terms.d);
      rsp_data_in.control_out = clamp_fn(CLAMP_W'(sum), cfg.out_lo, cfg.out_hi);
      rsp_data_in.updated     = b.updated;
      rsp_data_in.out_limited = (sum >= SUM_W'(cfg.out_hi)) || (sum <= SUM_W'(cfg.out_lo));
      rsp_data_in.p_limited   = (terms.p >= cfg.p_hi) || (terms.p <= cfg.p_lo);
      rsp_data_in.i_limited   = (terms.i >= cfg.int_hi) || (terms.i <= cfg.int_lo);
      rsp_data_in.d_limited   = (terms.d >= cfg.d_hi) || (terms.d <= cfg.d_lo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (c_ready) begin
         rsp_valid_ff <= b.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PDC_ASSERT_RESET(a_rsp_idle_after_reset, reset |=> !rsp_valid_ff, "result valid right after reset")

endmodule

[sv/pid_deadband_clamped_controller.sv]
// top level of the pid controller with input deadband and clamped terms
`timescale 1ns / 1ps

//  channel   direction  handshake              payload
//  req       in         req_valid/req_ready    req_data: mode, sample
//  rsp       out        rsp_valid/rsp_ready    rsp_data: control_out, updated, flags
//  csr       in         csr_write              csr_index, csr_wdata
//
//  one beat per cycle sustained while rsp is not stalled; a result passes
//  through the input register, term register and result register
//  the integral and previous-value recurrence closes inside the term stage,
//  which is what holds the rate at one beat per cycle
//  reset (synchronous) empties the pipe, zeroes the terms and loads the
//  register defaults; no clearing pass is needed
//  a stalled rsp holds each full stage whose successor is full; req_ready
//  drops only once all three stages are full

module pid_deadband_clamped_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pdc_pkg::req_payload_type             req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output pdc_pkg::rsp_payload_type             rsp_data,
   input  logic                                 csr_write,
   input  logic [pdc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [pdc_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import pdc_pkg::*;

   cfg_type     cfg;      // unpacked gains and limits
   stage_a_type a_stage;  // offset sample and its count decision
   stage_b_type b_stage;  // marks a beat whose terms sit in the state
   terms_type   terms;    // current p, i and d
   logic        b_ready;  // term stage can take a beat
   logic        c_ready;  // result register can take a beat

   // configuration registers
   pdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // deadband, window and trigger subtraction into the input register
   pdc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg),
      .b_ready   (b_ready),
      .a_out     (a_stage)
   );

   // three products, term clamps and the integral update
   pdc_terms u_terms (
      .clock   (clock),
      .reset   (reset),
      .a       (a_stage),
      .cfg     (cfg),
      .b_ready (b_ready),
      .c_ready (c_ready),
      .b_out   (b_stage),
      .terms   (terms)
   );

   // sum, output clamp and flags into the result register
   pdc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .b         (b_stage),
      .terms     (terms),
      .cfg       (cfg),
      .c_ready   (c_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
